// ----- rtl/core/ntsu_pkg.sv -----
// Shared types, constants and helpers for the NTP seconds to UTC date unit.
`timescale 1ns / 1ps

package ntsu_pkg;

  // Input transfer payload
  typedef struct packed {
    logic [31:0] ntp_seconds;
    logic [31:0] ntp_fraction;
  } in_t;

  // Result transfer payload
  typedef struct packed {
    logic [11:0] calendar_year;
    logic [3:0]  month_of_year;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [6:0]  hundredths;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAYS,
    ST_HOUR,
    ST_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  // Operand select for the shared compare/subtract unit
  typedef enum logic [2:0] {
    OP_EPOCH,
    OP_DAY,
    OP_HOUR,
    OP_MIN,
    OP_YEAR,
    OP_MONTH
  } op_sel_t;

  typedef struct packed {
    op_sel_t    sel;
    logic [3:0] shamt;
    logic       leap;
    logic [3:0] mon;
  } unit_ctl_t;

  localparam logic [31:0] EPOCH_OFFSET = 32'd2208988800;
  localparam logic [31:0] DAY_SECS     = 32'd86400;
  localparam logic [31:0] HOUR_SECS    = 32'd3600;
  localparam logic [31:0] MIN_SECS     = 32'd60;
  localparam logic [31:0] YEAR_DAYS    = 32'd365;
  localparam logic [31:0] LEAP_DAYS    = 32'd366;
  localparam logic [11:0] BASE_YEAR    = 12'd1970;

  // 1970 residues for the leap rule counters
  localparam logic [1:0] BASE_MOD4   = 2'd2;
  localparam logic [6:0] BASE_MOD100 = 7'd70;
  localparam logic [8:0] BASE_MOD400 = 9'd370;
  localparam logic [6:0] LAST_MOD100 = 7'd99;
  localparam logic [8:0] LAST_MOD400 = 9'd399;

  // Top quotient bit index per division pass (16, 5 and 6 bits)
  localparam logic [3:0] DAY_TOP_STEP  = 4'd15;
  localparam logic [3:0] HOUR_TOP_STEP = 4'd4;
  localparam logic [3:0] MIN_TOP_STEP  = 4'd5;

  // Zero-based month indexes
  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_APR = 4'd3;
  localparam logic [3:0] MON_JUN = 4'd5;
  localparam logic [3:0] MON_SEP = 4'd8;
  localparam logic [3:0] MON_NOV = 4'd10;
  localparam logic [3:0] MON_DEC = 4'd11;

  localparam logic [14:0] HUND_SCALE = 15'd100;

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    if (mon == MON_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (mon inside {MON_APR, MON_JUN, MON_SEP, MON_NOV}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// ----- rtl/core/ntsu_cmpsub.sv -----
// Shared compare/subtract unit with its operand selection.
`timescale 1ns / 1ps

module ntsu_cmpsub (
  input  logic [31:0]        a,
  input  ntsu_pkg::unit_ctl_t ctl,
  output logic               ge,
  output logic [31:0]        diff
);
  import ntsu_pkg::*;

  logic [31:0] b;
  logic [32:0] wide;

  always_comb begin
    case (ctl.sel)
      OP_EPOCH: b = EPOCH_OFFSET;
      OP_DAY:   b = DAY_SECS << ctl.shamt;
      OP_HOUR:  b = HOUR_SECS << ctl.shamt;
      OP_MIN:   b = MIN_SECS << ctl.shamt;
      OP_YEAR:  b = ctl.leap ? LEAP_DAYS : YEAR_DAYS;
      OP_MONTH: b = {27'd0, month_days(ctl.mon, ctl.leap)};
      default:  b = EPOCH_OFFSET;
    endcase
  end

  // Borrow out of the 33-bit subtract means a < b
  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[31:0];
  assign ge   = ~wide[32];

endmodule

// ----- rtl/core/ntp_seconds_to_utc_date_unit.sv -----
// Top level: NTP seconds and fraction to UTC calendar date and time of day.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready/in_data) takes one NTP timestamp: 32-bit
//   seconds of era 0 and the 32-bit fraction. Result channel (out_valid/
//   out_ready/out_data) returns one UTC date and time of day per input transfer.
//   One compare/subtract unit does all but the hundredths under a sequencer:
//     epoch offset subtract (32-bit wrap, pre-1970 maps to 2036..2106)
//     restoring divide by 86400 (days, time of day)
//     divides by 3600 and 60 (hour, minute, remainder is second)
//     year walk from 1970, one year per cycle
//     month walk, one month per cycle
//     result load into the output register
//   The next item can be taken in the cycle after the load.
//   in_ready is high only while the sequencer is idle, so one item
//   is in flight; a finished result may sit in the output register while the
//   next item is taken and worked on. If the receiver still holds off when that
//   next result is ready, the sequencer waits in its final state.
//   Reset (rst_n low, synchronous) returns to idle and drops out_valid.

module ntp_seconds_to_utc_date_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ntsu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ntsu_pkg::out_t out_data
);
  import ntsu_pkg::*;

  state_t      state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [31:0] acc_r, acc_nxt;       // working remainder
  logic [15:0] days_r, days_nxt;     // day quotient
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [6:0]  hund_r, hund_nxt;
  logic [11:0] year_r, year_nxt;
  logic [1:0]  mod4_r, mod4_nxt;
  logic [6:0]  mod100_r, mod100_nxt;
  logic [8:0]  mod400_r, mod400_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  unit_ctl_t   ctl;
  logic [31:0] unit_a;
  logic        ge;
  logic [31:0] diff;
  logic [31:0] rem;
  logic        leap;
  logic        out_load;
  logic [14:0] hund_prod;

  assign leap = ((mod4_r == 2'd0) && (mod100_r != 7'd0)) || (mod400_r == 9'd0);
  assign rem  = ge ? diff : acc_r;
  assign hund_prod = {7'd0, in_data.ntp_fraction[31:24]} * HUND_SCALE;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  ntsu_cmpsub u_cmpsub (
    .a    (unit_a),
    .ctl  (ctl),
    .ge   (ge),
    .diff (diff)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_DAYS;
      ST_DAYS:  if (step_r == 4'd0) state_nxt = ST_HOUR;
      ST_HOUR:  if (step_r == 4'd0) state_nxt = ST_MIN;
      ST_MIN:   if (step_r == 4'd0) state_nxt = ST_YEAR;
      ST_YEAR:  if (!ge) state_nxt = ST_MONTH;
      ST_MONTH: if ((mon_r == MON_DEC) || !ge) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and unit control
  always_comb begin
    in_ready  = 1'b0;
    unit_a    = acc_r;
    ctl.sel   = OP_EPOCH;
    ctl.shamt = step_r;
    ctl.leap  = leap;
    ctl.mon   = mon_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        unit_a   = in_data.ntp_seconds;
      end
      ST_DAYS:  ctl.sel = OP_DAY;
      ST_HOUR:  ctl.sel = OP_HOUR;
      ST_MIN:   ctl.sel = OP_MIN;
      ST_YEAR:  ctl.sel = OP_YEAR;
      ST_MONTH: ctl.sel = OP_MONTH;
      default:  ctl.sel = OP_EPOCH;
    endcase
  end

  // Datapath
  always_comb begin
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    days_nxt      = days_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    sec_nxt       = sec_r;
    hund_nxt      = hund_r;
    year_nxt      = year_r;
    mod4_nxt      = mod4_r;
    mod100_nxt    = mod100_r;
    mod400_nxt    = mod400_r;
    mon_nxt       = mon_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          acc_nxt    = diff;            // unix time, wraps mod 2^32
          step_nxt   = DAY_TOP_STEP;
          days_nxt   = '0;
          hour_nxt   = '0;
          min_nxt    = '0;
          mon_nxt    = '0;
          year_nxt   = BASE_YEAR;
          mod4_nxt   = BASE_MOD4;
          mod100_nxt = BASE_MOD100;
          mod400_nxt = BASE_MOD400;
          hund_nxt   = hund_prod[14:8];
        end
      end
      ST_DAYS: begin
        acc_nxt  = rem;
        days_nxt = {days_r[14:0], ge};
        step_nxt = (step_r == 4'd0) ? HOUR_TOP_STEP : step_r - 4'd1;
      end
      ST_HOUR: begin
        acc_nxt  = rem;
        hour_nxt = {hour_r[3:0], ge};
        step_nxt = (step_r == 4'd0) ? MIN_TOP_STEP : step_r - 4'd1;
      end
      ST_MIN: begin
        acc_nxt  = rem;
        min_nxt  = {min_r[4:0], ge};
        step_nxt = step_r - 4'd1;
        if (step_r == 4'd0) begin
          sec_nxt = rem[5:0];
          acc_nxt = {16'd0, days_r};
        end
      end
      ST_YEAR: begin
        if (ge) begin
          acc_nxt    = diff;
          year_nxt   = year_r + 12'd1;
          mod4_nxt   = mod4_r + 2'd1;
          mod100_nxt = (mod100_r == LAST_MOD100) ? 7'd0 : mod100_r + 7'd1;
          mod400_nxt = (mod400_r == LAST_MOD400) ? 9'd0 : mod400_r + 9'd1;
        end
      end
      ST_MONTH: begin
        if ((mon_r != MON_DEC) && ge) begin
          acc_nxt = diff;
          mon_nxt = mon_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.calendar_year    = year_r;
          out_data_nxt.month_of_year    = mon_r + 4'd1;
          out_data_nxt.day_of_month     = acc_r[4:0] + 5'd1;
          out_data_nxt.hour_of_day      = hour_r;
          out_data_nxt.minute_of_hour   = min_r;
          out_data_nxt.second_of_minute = sec_r;
          out_data_nxt.hundredths       = hund_r;
        end
      end
      default: begin
        step_nxt = step_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    days_r     <= days_nxt;
    hour_r     <= hour_nxt;
    min_r      <= min_nxt;
    sec_r      <= sec_nxt;
    hund_r     <= hund_nxt;
    year_r     <= year_nxt;
    mod4_r     <= mod4_nxt;
    mod100_r   <= mod100_nxt;
    mod400_r   <= mod400_nxt;
    mon_r      <= mon_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only one item in flight
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("in_ready high while sequencer busy");

  // Each transfer starts the day divide with a full quotient count
  a_start_divide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DAYS) && (step_r == DAY_TOP_STEP))
    else $error("day divide not started after input transfer");

  // Year walk advances the year exactly once per consumed year
  a_year_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR) && ge |=> (year_r == $past(year_r) + 12'd1))
    else $error("year walk step lost");

  // A pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && !out_ready |=> (state_r == ST_DONE))
    else $error("result loaded over a stalled one");

endmodule

// ----- verif/ntp_seconds_to_utc_date_unit_test.sv -----
// Self-checking testbench for the NTP seconds to UTC date unit.
`timescale 1ns / 1ps

module ntp_seconds_to_utc_date_unit_test;

  import ntsu_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned IDLE_PERCENT  = 32;
  localparam int unsigned DRAIN_CYCLES  = 200;   // beyond the worst-case latency
  localparam int unsigned LONG_HOLD     = 400;   // receiver hold-off for the fill-up test
  localparam logic [31:0] SECS_IN_DAY   = 32'd86400;
  localparam logic [31:0] SECS_IN_HOUR  = 32'd3600;
  localparam logic [31:0] LAST_UNIX_DAY = 32'd49710;

  // Days per month, January first; February is patched for leap years.
  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;

  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Expected dates, oldest first
  out_t date_queue [$];

  bit          gaps_on;            // random idling on both sides
  int unsigned sink_hold_cycles;   // receiver hold-off still to run
  int unsigned cycle_count;
  int unsigned sent_count;
  int unsigned wrapped_count;      // timestamps before 1970
  int unsigned checked_count;
  int unsigned error_count;

  ntp_seconds_to_utc_date_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Gregorian leap rule
  function automatic bit gregorian_leap(input logic [11:0] yr);
    int unsigned y;
    y = yr;
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Era-0 NTP seconds into civil date, time of day and hundredths.
  function automatic out_t utc_date_of(input in_t stamp);
    logic [31:0] unix_secs;
    logic [31:0] day_left;
    logic [31:0] tod;
    logic [11:0] yr;
    logic [3:0]  mon;
    int unsigned year_len;
    int unsigned mon_len;
    bit          leap;
    bit          walking;
    out_t        date;
    unix_secs = stamp.ntp_seconds - EPOCH_OFFSET;   // wraps for pre-1970 input
    day_left  = unix_secs / SECS_IN_DAY;
    tod       = unix_secs % SECS_IN_DAY;
    yr        = BASE_YEAR;
    walking   = 1'b1;
    while (walking) begin
      year_len = gregorian_leap(yr) ? 366 : 365;
      if (day_left < year_len) begin
        walking = 1'b0;
      end else begin
        day_left -= year_len;
        yr++;
      end
    end
    leap    = gregorian_leap(yr);
    mon     = 4'd0;
    walking = 1'b1;
    // December absorbs whatever is left
    while (walking && mon < MON_DEC) begin
      mon_len = (mon == MON_FEB && leap) ? 29 : MONTH_LEN[mon];
      if (day_left < mon_len) begin
        walking = 1'b0;
      end else begin
        day_left -= mon_len;
        mon++;
      end
    end
    date.calendar_year    = yr;
    date.month_of_year    = mon + 4'd1;
    date.day_of_month     = 5'(day_left + 1);
    date.hour_of_day      = 5'(tod / SECS_IN_HOUR);
    date.minute_of_hour   = 6'((tod % SECS_IN_HOUR) / 60);
    date.second_of_minute = 6'(tod % 60);
    date.hundredths       = 7'((int'(stamp.ntp_fraction[31:24]) * 100) / 256);
    return date;
  endfunction

  function automatic logic [31:0] ntp_of_unix(input logic [31:0] unix_secs);
    return unix_secs + EPOCH_OFFSET;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one timestamp per call, starting and ending on a rising edge.
  // in_valid is left high after the transfer; the next call lowers it only if
  // it idles, so it never gets two updates in one step.
  // ---------------------------------------------------------------------------
  task automatic send_timestamp(input logic [31:0] secs, input logic [31:0] frac);
    in_t stamp;
    stamp.ntp_seconds  = secs;
    stamp.ntp_fraction = frac;
    while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= stamp;
    // in_ready is stable mid-cycle; transfer happens on the following edge
    do begin
      @(negedge clk);
    end while (!in_ready);
    @(posedge clk);
    date_queue.push_back(utc_date_of(stamp));
    sent_count++;
    if (secs < EPOCH_OFFSET) begin
      wrapped_count++;
    end
  endtask

  // Random timestamp, biased toward day edges, the 1970 wrap and the range ends
  task automatic send_random_timestamp();
    logic [31:0] secs;
    logic [31:0] unix_day;
    case ($urandom_range(0, 3))
      0: begin
        secs = $urandom;
      end
      1: begin
        // first or last second of a random day
        unix_day = $urandom_range(0, LAST_UNIX_DAY - 1);
        secs = ntp_of_unix(unix_day * SECS_IN_DAY + ($urandom_range(0, 1) ? 32'd86399 : 32'd0));
      end
      2: begin
        // around the 1970 wrap point and the ends of the 32-bit range
        case ($urandom_range(0, 2))
          0:       secs = EPOCH_OFFSET + 32'($urandom_range(0, 400)) - 32'd200;
          1:       secs = 32'($urandom_range(0, 200));
          default: secs = 32'hFFFF_FFFF - 32'($urandom_range(0, 200));
        endcase
      end
      default: begin
        unix_day = $urandom_range(0, LAST_UNIX_DAY - 1);
        secs = ntp_of_unix(unix_day * SECS_IN_DAY + 32'($urandom_range(0, 86399)));
      end
    endcase
    send_timestamp(secs, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        out_ready <= 1'b0;
        sink_hold_cycles--;
      end else if (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker; sampled mid-cycle, the transfer lands on the next edge
  initial begin
    out_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (date_queue.size() == 0) begin
          $error("unexpected result transfer: year %0d month %0d day %0d",
                 out_data.calendar_year, out_data.month_of_year, out_data.day_of_month);
          error_count++;
        end else begin
          want = date_queue.pop_front();
          checked_count++;
          if (out_data.calendar_year !== want.calendar_year) begin
            $error("calendar_year: expected %0d, actual %0d",
                   want.calendar_year, out_data.calendar_year);
            error_count++;
          end
          if (out_data.month_of_year !== want.month_of_year) begin
            $error("month_of_year: expected %0d, actual %0d",
                   want.month_of_year, out_data.month_of_year);
            error_count++;
          end
          if (out_data.day_of_month !== want.day_of_month) begin
            $error("day_of_month: expected %0d, actual %0d",
                   want.day_of_month, out_data.day_of_month);
            error_count++;
          end
          if (out_data.hour_of_day !== want.hour_of_day) begin
            $error("hour_of_day: expected %0d, actual %0d",
                   want.hour_of_day, out_data.hour_of_day);
            error_count++;
          end
          if (out_data.minute_of_hour !== want.minute_of_hour) begin
            $error("minute_of_hour: expected %0d, actual %0d",
                   want.minute_of_hour, out_data.minute_of_hour);
            error_count++;
          end
          if (out_data.second_of_minute !== want.second_of_minute) begin
            $error("second_of_minute: expected %0d, actual %0d",
                   want.second_of_minute, out_data.second_of_minute);
            error_count++;
          end
          if (out_data.hundredths !== want.hundredths) begin
            $error("hundredths: expected %0d, actual %0d",
                   want.hundredths, out_data.hundredths);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("watchdog expired after %0d cycles, %0d results outstanding",
             cycle_count, date_queue.size());
    $display("ntp_seconds_to_utc_date_unit_test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Range ends, 1970 wrap, leap rule corners, fraction byte ends
  task automatic test_directed();
    gaps_on = 1'b1;
    send_timestamp(EPOCH_OFFSET, 32'h0000_0000);                  // 1970-01-01 00:00:00
    send_timestamp(EPOCH_OFFSET - 32'd1, 32'hFFFF_FFFF);          // wraps to 2106-02-07
    send_timestamp(32'h0000_0000, 32'h0000_0000);                 // 2036 wrap start
    send_timestamp(32'hFFFF_FFFF, 32'hFFFF_FFFF);                 // top of the input range
    send_timestamp(ntp_of_unix(32'd94694399), 32'h8000_0000);     // 1972-12-31, day 366
    send_timestamp(ntp_of_unix(32'd68255999), 32'h00FF_FFFF);     // 1972-02-29 end, low bits only
    send_timestamp(ntp_of_unix(32'd951782400), 32'h0100_0000);    // 2000-02-29, leap by 400
    send_timestamp(ntp_of_unix(32'd946684799), 32'hFE00_0000);    // 1999-12-31 23:59:59
    send_timestamp(ntp_of_unix(32'd4107542399), 32'h4000_0000);   // 2100-02-28, not leap
    send_timestamp(ntp_of_unix(32'd4107542400), 32'hC000_0000);   // 2100-03-01
    send_timestamp(ntp_of_unix(32'd1483228799), 32'h0300_0000);   // 2016-12-31
    send_timestamp(ntp_of_unix(32'd2147483647), 32'h7FFF_FFFF);   // 2038-01-19 03:14:07
    send_timestamp(ntp_of_unix(32'd2147483648), 32'hA5A5_A5A5);
    send_timestamp(ntp_of_unix(32'd86399), 32'h5A5A_5A5A);        // first day, last second
    send_timestamp(ntp_of_unix(32'd86400), 32'h0000_0001);
  endtask

  // Back-to-back traffic, both sides always ready
  task automatic test_random_streaming(input int unsigned n);
    gaps_on = 1'b0;
    repeat (n) send_random_timestamp();
  endtask

  // Random traffic with idling on both sides
  task automatic test_random_gaps(input int unsigned n);
    gaps_on = 1'b1;
    repeat (n) send_random_timestamp();
  endtask

  // Receiver holds off while the sender keeps offering; the block fills and
  // must stall its input without losing a result.
  task automatic test_receiver_hold();
    gaps_on = 1'b0;
    @(negedge clk);
    sink_hold_cycles = LONG_HOLD;
    @(posedge clk);
    repeat (6) send_random_timestamp();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_streaming(100);
    test_receiver_hold();
    test_random_gaps(400);

    in_valid <= 1'b0;
    while (date_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d timestamps (%0d before 1970), checked %0d dates, %0d errors.",
             sent_count, wrapped_count, checked_count, error_count);
    $display("Covered range ends, leap corners, back-to-back, random idling, long stall.");
    if (error_count == 0) begin
      $display("ntp_seconds_to_utc_date_unit_test passed");
    end else begin
      $display("ntp_seconds_to_utc_date_unit_test failed");
    end
    $finish;
  end

endmodule
